FILE: sv/f32f16_pkg.sv
// Shared constants and stage types for the binary32/binary16 converter.
`default_nettype none
package f32f16_pkg;
   localparam logic [15:0] H_EXP_ALL = 16'h7c00;
   localparam logic [15:0] H_QUIET   = 16'h0200;
   localparam logic [31:0] S_EXP_ALL = 32'h7f800000;

   typedef enum logic {
      ACT_NARROW = 1'b0,
      ACT_WIDEN  = 1'b1
   } action_type;

   // stage 1 -> stage 2 decoded operand
   typedef struct packed {
      action_type act;
      logic       sgn;
      logic       special;   // result fully known already
      logic [31:0] fixed;    // that result
      logic       sub;       // narrow: half subnormal path
      logic [4:0] sh_lo;     // narrow subnormal: shift - 14 (0..10)
      logic [4:0] he;        // narrow normal: half exponent
      logic [23:0] m;        // mantissa with hidden bit
   } dec_type;

   // stage 2 -> stage 3 aligned value and round bits
   typedef struct packed {
      action_type act;
      logic       sgn;
      logic       special;
      logic [31:0] fixed;
      logic [4:0] he;
      logic [10:0] q;
      logic       rnd_up;
   } aln_type;
endpackage
`default_nettype wire

FILE: sv/f32f16_core.sv
// Three-stage conversion datapath with stall-aware valid bits.
`default_nettype none
module f32f16_core (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     adv,      // pipeline advances this cycle
   input  wire logic                     in_valid,
   input  wire f32f16_pkg::action_type   in_act,
   input  wire logic [31:0]              in_op,
   output logic                          out_valid,
   output logic [31:0]                   out_data
);
   import f32f16_pkg::*;

   dec_type     s1_in, s1_ff;
   aln_type     s2_in, s2_ff;
   logic [31:0] s3_in, s3_ff;
   logic [2:0]  v_ff;

   // stage 1: decode
   always_comb begin
      logic [7:0] e;
      logic [22:0] mm;
      logic [4:0] he5, ee;
      logic [9:0] hm, nm;
      logic [3:0] lz;
      s1_in = '0;
      s1_in.act = in_act;
      e = in_op[30:23];
      mm = in_op[22:0];
      hm = in_op[9:0];
      ee = in_op[14:10];
      lz = 4'd0;
      nm = hm;
      he5 = 5'd0;
      if (in_act == ACT_NARROW) begin
         s1_in.sgn = in_op[31];
         s1_in.m = {1'b1, mm};
         if (e == 8'hff) begin
            s1_in.special = 1'b1;
            s1_in.fixed = {16'd0, in_op[31], 15'd0} | {16'd0, H_EXP_ALL}
               | ((mm == 23'd0) ? 32'd0 : {22'd0, mm[22:13]} | {16'd0, H_QUIET});
         end else if (e >= 8'd143) begin
            s1_in.special = 1'b1;
            s1_in.fixed = {16'd0, in_op[31], 15'd0} | {16'd0, H_EXP_ALL};
         end else if (e < 8'd102) begin
            s1_in.special = 1'b1;
            s1_in.fixed = {16'd0, in_op[31], 15'd0};
         end else if (e <= 8'd112) begin
            s1_in.sub = 1'b1;
            s1_in.sh_lo = 5'(8'd112 - e);
         end else begin
            s1_in.he = 5'(e - 8'd112);
         end
      end else begin
         s1_in.special = 1'b1;
         if (ee == 5'd0) begin
            if (hm == 10'd0) begin
               s1_in.fixed = {in_op[15], 31'd0};
            end else begin
               for (int i = 9; i >= 0; i--) begin
                  if (hm[i] && lz == 4'd0 && nm == hm) begin
                     lz = 4'(10 - i);
                     nm = 10'(hm << (10 - i));
                  end
               end
               s1_in.fixed = {in_op[15], 8'(8'd113 - {4'd0, lz}), nm, 13'd0};
            end
         end else if (ee == 5'h1f) begin
            s1_in.fixed = {in_op[15], 31'd0} | S_EXP_ALL | {9'd0, hm, 13'd0};
         end else begin
            he5 = ee;
            s1_in.fixed = {in_op[15], 8'({3'd0, he5} + 8'd112), hm, 13'd0};
         end
      end
   end

   // stage 2: align and decide rounding
   always_comb begin
      logic [4:0] sh;
      logic [23:0] rem, half;
      logic [10:0] q;
      s2_in.act = s1_ff.act;
      s2_in.sgn = s1_ff.sgn;
      s2_in.special = s1_ff.special;
      s2_in.fixed = s1_ff.fixed;
      s2_in.he = s1_ff.sub ? 5'd0 : s1_ff.he;
      sh = s1_ff.sub ? 5'(s1_ff.sh_lo + 5'd14) : 5'd13;
      q = 11'(s1_ff.m >> sh);
      if (!s1_ff.sub) q = {1'b0, s1_ff.m[22:13]};
      rem = s1_ff.m & ((24'd1 << sh) - 24'd1);
      half = 24'd1 << (sh - 5'd1);
      s2_in.q = q;
      s2_in.rnd_up = (rem > half) || (rem == half && q[0]);
   end

   // stage 3: increment, carry into exponent
   always_comb begin
      logic [10:0] q;
      logic [5:0] he;
      q = s2_ff.q + {10'd0, s2_ff.rnd_up};
      he = {1'b0, s2_ff.he};
      if (s2_ff.special) begin
         s3_in = s2_ff.fixed;
      end else if (s2_ff.he == 5'd0) begin
         s3_in = {16'd0, s2_ff.sgn, 4'd0, q};   // carry into bit 10 = min normal
      end else begin
         if (q[10]) begin
            he = he + 6'd1;
            q = 11'd0;
         end
         if (he >= 6'd31) s3_in = {16'd0, s2_ff.sgn, 15'd0} | {16'd0, H_EXP_ALL};
         else s3_in = {16'd0, s2_ff.sgn, he[4:0], q[9:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[1:0], in_valid};
      end
      if (adv) begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         s3_ff <= s3_in;
      end
   end

   assign out_valid = v_ff[2];
   assign out_data  = s3_ff;
endmodule
`default_nettype wire

FILE: sv/fp32_fp16_converter.sv
// Top level: stream wrapper around the binary32/binary16 conversion pipeline.
//   channel | dir | tdata                          | tuser
//   req     | in  | [31:0] operand                 | [0] action
//   rsp     | out | [31:0] converted               | -
// One beat per cycle unless stalled; each beat passes the decode, align and
// round stages. Reset clears the stage valid bits only. The whole pipeline
// holds while the output stage is full and rsp_tready is low; bubbles stay put.
`default_nettype none
module fp32_fp16_converter (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // operand
   input  wire logic [0:0]  req_tuser,   // action
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata    // converted
);
   import f32f16_pkg::*;

   logic adv;
   assign adv = rsp_tready || !rsp_tvalid;
   assign req_tready = adv;

   f32f16_core u_core (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_tvalid),
      .in_act    (action_type'(req_tuser[0])),
      .in_op     (req_tdata),
      .out_valid (rsp_tvalid),
      .out_data  (rsp_tdata)
   );
endmodule
`default_nettype wire
